// ----- rtl/core/uts_pkg.sv -----
// Shared types, widths and constants of the USB transfer TRB splitter.
// Used by every module of the block; depends on nothing else.

package uts_pkg;

  localparam int LEN_W      = 24;
  localparam int MBP_W      = 16;
  localparam int MPS_W      = 11;
  localparam int IDX_W      = 6;
  localparam int PK_W       = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_TRBS    = 64;
  localparam int TD_SIZE_CAP = 31;

  // Largest legal byte count is MAX_TRBS times the configured burst size.
  localparam int LIMIT_W = MBP_W + $clog2(MAX_TRBS + 1);
  localparam int CMP_W   = (LIMIT_W > LEN_W) ? LIMIT_W : LEN_W;

  // Packet thresholds k * max_packet_size for k below the TD size cap.
  localparam int THR_W = MPS_W + $clog2(TD_SIZE_CAP);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BURST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET = CFG_IDX_W'(1);

  typedef struct packed {
    logic [MBP_W-1:0] mbp;
    logic [MPS_W-1:0] mps;
  } cfg_t;

  typedef struct packed {
    logic             err;
    logic [LEN_W-1:0] total;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

endpackage

// ----- rtl/core/uts_front.sv -----
// Front end of the TRB splitter: accepts a transfer length and classifies it.
// Depends on uts_pkg.

module uts_front import uts_pkg::*; (
  input  logic             start,
  input  logic [LEN_W-1:0] in_total_length,
  input  cfg_t             cfg,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output q_entry_t         entry
);

  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] total_ext;

  // A transfer needs too many chunks when it exceeds MAX_TRBS full chunks.
  assign limit     = CMP_W'(cfg.mbp) * CMP_W'(MAX_TRBS);
  assign total_ext = CMP_W'(in_total_length);

  assign busy        = q_full;
  assign push        = start & ~q_full;
  assign entry.err   = total_ext > limit;
  assign entry.total = in_total_length;

endmodule

// ----- rtl/core/uts_queue.sv -----
// Short queue of classified transfers between the front and back ends.
// Depends on uts_pkg.

module uts_queue import uts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_ctrl_t  ctrl,
  input  q_entry_t wr_entry,
  output q_entry_t rd_entry,
  output logic     full,
  output logic     empty
);

  q_entry_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = cnt_r == QCNT_W'(QDEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = ctrl.push & ~full;
  assign do_pop   = ctrl.pop & ~empty;
  assign rd_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ----- rtl/core/uts_back.sv -----
// Back end of the TRB splitter: walks one transfer chunk by chunk and
// computes the TD size of each chunk. Depends on uts_pkg.

module uts_back import uts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_empty,
  input  q_entry_t          q_entry,
  output logic              pop,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_chunk_index,
  output logic [MBP_W-1:0]  out_chunk_length,
  output logic [PK_W-1:0]   out_packets_after,
  output logic              out_chain_flag,
  output logic              out_interrupt_on_done,
  output logic              out_first_chunk,
  output logic              out_error_code,
  output logic              out_last
);

  back_state_t      state_r, state_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             first_r, first_nxt;
  logic             err_r, err_nxt;

  logic             chunk_fin;
  logic [MBP_W-1:0] chunk_len;
  logic [LEN_W-1:0] rem_left;

  // Chunk stage registers.
  logic             s1_valid_r, s1_valid_nxt;
  logic [IDX_W-1:0] s1_idx_r, s1_idx_nxt;
  logic [MBP_W-1:0] s1_len_r, s1_len_nxt;
  logic [LEN_W-1:0] s1_rem_r, s1_rem_nxt;
  logic             s1_fin_r, s1_fin_nxt;
  logic             s1_first_r, s1_first_nxt;
  logic             s1_err_r, s1_err_nxt;

  // Output stage registers.
  logic             o_valid_r;
  logic [IDX_W-1:0] o_idx_r;
  logic [MBP_W-1:0] o_len_r;
  logic [PK_W-1:0]  o_pk_r;
  logic             o_chain_r;
  logic             o_ioc_r;
  logic             o_first_r;
  logic             o_err_r;
  logic             o_last_r;

  logic [THR_W-1:0]       thr_r [TD_SIZE_CAP];
  logic [TD_SIZE_CAP-1:0] therm;
  logic [PK_W-1:0]        pk;

  assign chunk_fin = rem_r <= LEN_W'(cfg.mbp);
  assign chunk_len = chunk_fin ? rem_r[MBP_W-1:0] : cfg.mbp;
  assign rem_left  = rem_r - LEN_W'(chunk_len);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (err_r || chunk_fin) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    rem_nxt      = rem_r;
    idx_nxt      = idx_r;
    first_nxt    = first_r;
    err_nxt      = err_r;
    s1_valid_nxt = 1'b0;
    s1_idx_nxt   = s1_idx_r;
    s1_len_nxt   = s1_len_r;
    s1_rem_nxt   = s1_rem_r;
    s1_fin_nxt   = s1_fin_r;
    s1_first_nxt = s1_first_r;
    s1_err_nxt   = s1_err_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          rem_nxt   = q_entry.total;
          idx_nxt   = '0;
          first_nxt = 1'b1;
          err_nxt   = q_entry.err;
        end
      end
      ST_RUN: begin
        s1_valid_nxt = 1'b1;
        if (err_r) begin
          s1_idx_nxt   = '0;
          s1_len_nxt   = '0;
          s1_rem_nxt   = '0;
          s1_fin_nxt   = 1'b1;
          s1_first_nxt = 1'b0;
          s1_err_nxt   = 1'b1;
        end else begin
          s1_idx_nxt   = idx_r;
          s1_len_nxt   = chunk_len;
          s1_rem_nxt   = rem_left;
          s1_fin_nxt   = chunk_fin;
          s1_first_nxt = first_r;
          s1_err_nxt   = 1'b0;
          rem_nxt      = rem_left;
          idx_nxt      = idx_r + 1'b1;
          first_nxt    = 1'b0;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Thresholds track configuration; user must change it only while idle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < TD_SIZE_CAP; k++) begin
      thr_r[k] <= THR_W'(k) * THR_W'(cfg.mps);
    end
  end

  // The remaining bytes exceed k packets for a run of low k; counting that
  // run gives the rounded-up packet count, already capped.
  always_comb begin
    for (int k = 0; k < TD_SIZE_CAP; k++) begin
      therm[k] = s1_rem_r > LEN_W'(thr_r[k]);
    end
    pk = PK_W'($countones(therm));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    first_r    <= first_nxt;
    err_r      <= err_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s1_len_r   <= s1_len_nxt;
    s1_rem_r   <= s1_rem_nxt;
    s1_fin_r   <= s1_fin_nxt;
    s1_first_r <= s1_first_nxt;
    s1_err_r   <= s1_err_nxt;
    o_idx_r    <= s1_idx_r;
    o_len_r    <= s1_len_r;
    o_pk_r     <= s1_err_r ? '0 : pk;
    o_chain_r  <= ~s1_fin_r & ~s1_err_r;
    o_ioc_r    <= s1_fin_r & ~s1_err_r;
    o_first_r  <= s1_first_r;
    o_err_r    <= s1_err_r;
    o_last_r   <= s1_fin_r;
  end

  assign out_valid             = o_valid_r;
  assign out_chunk_index       = o_idx_r;
  assign out_chunk_length      = o_len_r;
  assign out_packets_after     = o_pk_r;
  assign out_chain_flag        = o_chain_r;
  assign out_interrupt_on_done = o_ioc_r;
  assign out_first_chunk       = o_first_r;
  assign out_error_code        = o_err_r;
  assign out_last              = o_last_r;

`ifndef SYNTH
  a_chain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_chain_r) |=> o_valid_r)
    else $error("chained chunk not followed by another chunk");

  a_chain_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_chain_r) |-> (!o_last_r && !o_ioc_r && !o_err_r))
    else $error("chained chunk marked as final");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_err_r) |-> (o_last_r && !o_first_r && o_len_r == '0))
    else $error("error result carries chunk data");

  a_run_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && !err_r && !chunk_fin) |=> (state_r == ST_RUN))
    else $error("transfer walk stopped before its final chunk");
`endif

endmodule

// ----- rtl/core/usb_transfer_trb_splitter_core.sv -----
// Top level of the USB transfer TRB splitter: configuration registers and
// the front end, queue and back end. Depends on uts_pkg, uts_front,
// uts_queue and uts_back.

// How the block is used:
// A transfer length is offered on in_total_length with start; it is taken at
// a rising edge where start is high and busy is low. The front end checks at
// once whether the transfer needs more than MAX_TRBS chunks and places it in
// a two-entry queue, so busy rises only when that queue is full.
// The back end takes one queued transfer at a time and, while it walks a
// transfer, emits one result per cycle on the out_ ports, each marked by
// out_valid for exactly one cycle. The receiver cannot stall; every result
// shown is taken. An accepted transfer passes through the queue, the back
// end's transfer registers, the chunk stage and the output stage. The back
// end pops a transfer in ST_IDLE, then stays in ST_RUN for each of its
// chunks (one for a zero length or an error); the TD size of each chunk is
// found by comparing the bytes left against registered packet-size multiples.
// Configuration is written through cfg_valid/cfg_ready (always ready); the
// user must write it only while the block is idle, which the block does not
// enforce. Writes to unknown indexes are ignored. Synchronous reset restores
// a burst payload of 1024 and a packet size of 512 bytes and empties the
// queue and pipeline.

module usb_transfer_trb_splitter_core import uts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [LEN_W-1:0]      in_total_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_chunk_index,
  output logic [MBP_W-1:0]      out_chunk_length,
  output logic [PK_W-1:0]       out_packets_after,
  output logic                  out_chain_flag,
  output logic                  out_interrupt_on_done,
  output logic                  out_first_chunk,
  output logic                  out_error_code,
  output logic                  out_last
);

  logic [MBP_W-1:0] mbp_r;
  logic [MPS_W-1:0] mps_r;
  cfg_t             cfg;
  logic             cfg_write;

  q_ctrl_t          q_ctrl;
  q_entry_t         q_wr_entry;
  q_entry_t         q_rd_entry;
  logic             q_full;
  logic             q_empty;

  // The configuration channel never stalls.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbp_r <= MBP_W'(1024);
      mps_r <= MPS_W'(512);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_BURST:  mbp_r <= cfg_data[MBP_W-1:0];
        REG_MAX_PACKET: mps_r <= cfg_data[MPS_W-1:0];
        default:        mbp_r <= mbp_r;
      endcase
    end
  end

  // A zero size in either register behaves as a size of one byte.
  assign cfg.mbp = (mbp_r == '0) ? MBP_W'(1) : mbp_r;
  assign cfg.mps = (mps_r == '0) ? MPS_W'(1) : mps_r;

  uts_front u_front (
    .start           (start),
    .in_total_length (in_total_length),
    .cfg             (cfg),
    .q_full          (q_full),
    .busy            (busy),
    .push            (q_ctrl.push),
    .entry           (q_wr_entry)
  );

  uts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .wr_entry (q_wr_entry),
    .rd_entry (q_rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  uts_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .q_empty               (q_empty),
    .q_entry               (q_rd_entry),
    .pop                   (q_ctrl.pop),
    .out_valid             (out_valid),
    .out_chunk_index       (out_chunk_index),
    .out_chunk_length      (out_chunk_length),
    .out_packets_after     (out_packets_after),
    .out_chain_flag        (out_chain_flag),
    .out_interrupt_on_done (out_interrupt_on_done),
    .out_first_chunk       (out_first_chunk),
    .out_error_code        (out_error_code),
    .out_last              (out_last)
  );

endmodule
